// ===== rtl/ibtc_pkg.sv =====
// ----------------------------------------------------------------------------
// ibtc_pkg
// Shared types and constants of the I2C bridge transfer control engine.
// ----------------------------------------------------------------------------
package ibtc_pkg;

    localparam int MAX_READ_BYTES  = 512;
    localparam int CHUNK_BYTES     = 61;
    localparam int WR_RD_WRITE_MAX = 16;
    localparam int WRITE_MAX       = 61;

    localparam int STORE_AW = $clog2(MAX_READ_BYTES);
    localparam int LEN_W    = 10;
    localparam int WLEN_W   = 6;
    localparam int CHUNK_W  = $clog2(CHUNK_BYTES + 1);
    localparam int ALU_W    = 16;

    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_WRITE_READ = 3'd1,
        CMD_WRITE      = 3'd2,
        CMD_FORCE_SEND = 3'd3,
        CMD_STATUS     = 3'd4,
        CMD_CANCEL     = 3'd5,
        CMD_BUS_BYTE   = 3'd6,
        CMD_BUS_DONE   = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK      = 2'd0,
        RES_TIMEOUT = 2'd1,
        RES_RETRY   = 2'd2,
        RES_NACK    = 2'd3
    } bus_res_t;

    typedef enum logic [1:0] {
        K_BUS_START = 2'd0,
        K_STATUS    = 2'd1,
        K_HEADER    = 2'd2,
        K_DATA      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        MS_IDLE     = 2'd0,
        MS_BUSY     = 2'd1,
        MS_COMPLETE = 2'd2,
        MS_ERROR    = 2'd3
    } main_t;

    typedef enum logic [2:0] {
        DET_NACK    = 3'd0,
        DET_TIMEOUT = 3'd1,
        DET_ARB     = 3'd2,
        DET_SUCCESS = 3'd5
    } detail_t;

    typedef enum logic [1:0] {
        XF_READ       = 2'd0,
        XF_WRITE      = 2'd1,
        XF_WRITE_READ = 2'd2
    } xfer_t;

    typedef enum logic {
        ALU_MIN,
        ALU_SUBSAT
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic                 we;
        logic [STORE_AW-1:0]  waddr;
        logic [7:0]           wdata;
        logic                 re;
        logic [STORE_AW-1:0]  raddr;
    } store_req_t;

    typedef enum logic [3:0] {
        S_READY,
        S_START_RD,
        S_START_WR,
        S_START_LOAD,
        S_STATUS_LOAD,
        S_FS_REMAIN,
        S_FS_LIMIT,
        S_FS_CHUNK,
        S_FS_HEADER,
        S_OUT_SINGLE,
        S_OUT_HEADER,
        S_OUT_DATA
    } state_t;

endpackage

// ===== rtl/ibtc_alu.sv =====
// ----------------------------------------------------------------------------
// ibtc_alu
// Shared compare unit: minimum or saturating subtract of two operands.
// ----------------------------------------------------------------------------
module ibtc_alu
(
    input  ibtc_pkg::alu_req_t              req,
    output logic [ibtc_pkg::ALU_W-1:0]      y
);

    always_comb
    begin
        unique case (req.op)
            ibtc_pkg::ALU_MIN:
            begin
                y = (req.a < req.b) ? req.a : req.b;
            end
            ibtc_pkg::ALU_SUBSAT:
            begin
                y = (req.a > req.b) ? (req.a - req.b) : '0;
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ibtc_store.sv =====
// ----------------------------------------------------------------------------
// ibtc_store
// Read data store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ibtc_store
(
    input  logic                    clk,
    input  ibtc_pkg::store_req_t    req,
    output logic [7:0]              rd_data
);

    logic [7:0] mem [ibtc_pkg::MAX_READ_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= mem[req.raddr];
        end
    end

endmodule

// ===== rtl/i2c_bridge_transfer_control.sv =====
// ----------------------------------------------------------------------------
// i2c_bridge_transfer_control
// Command and status engine of a host-to-I2C bridge.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until all of its results
// have been taken. Cancel, bus byte and bus done give no result. A status
// request loads its result and then presents it. A start request does two
// clamps on the shared min/subtract unit, then the load of the bus-start
// result, then presents the result. A force send computes remaining length,
// host limit and chunk limit on the shared unit, then loads the header, then
// gives one result per cycle while out_stall is low: header plus up to 61
// data bytes, read from the 512-byte store through its single registered
// read port.
// ----------------------------------------------------------------------------
module i2c_bridge_transfer_control
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  address_byte,
    input  logic [15:0] length,
    input  logic [7:0]  write_count,
    input  logic [7:0]  data_byte,
    input  logic [1:0]  bus_result,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  status_main,
    output logic [2:0]  status_detail,
    output logic [6:0]  target,
    output logic [1:0]  transfer_kind,
    output logic [9:0]  read_count,
    output logic [5:0]  write_bytes,
    output logic [9:0]  byte_count,
    output logic [7:0]  read_data,
    output logic        last
);

    localparam int LW = ibtc_pkg::LEN_W;
    localparam int WW = ibtc_pkg::WLEN_W;
    localparam int CW = ibtc_pkg::CHUNK_W;
    localparam int AW = ibtc_pkg::ALU_W;
    localparam int SW = ibtc_pkg::STORE_AW;

    ibtc_pkg::state_t    state_reg, state_next;
    ibtc_pkg::cmd_t      cmd_reg, cmd_next;
    logic [15:0]         len_reg, len_next;
    logic [7:0]          wcnt_reg, wcnt_next;

    ibtc_pkg::main_t     main_reg, main_next;
    ibtc_pkg::detail_t   detail_reg, detail_next;
    logic [LW-1:0]       done_len_reg, done_len_next;
    logic [LW-1:0]       offset_reg, offset_next;
    logic [LW-1:0]       prd_len_reg, prd_len_next;
    logic [WW-1:0]       pwr_len_reg, pwr_len_next;
    ibtc_pkg::xfer_t     pkind_reg, pkind_next;
    logic [6:0]          ptarget_reg, ptarget_next;
    logic [LW-1:0]       fill_reg, fill_next;

    logic [LW-1:0]       tmp_reg, tmp_next;
    logic [CW-1:0]       chunk_reg, chunk_next;
    logic [CW-1:0]       idx_reg, idx_next;

    logic                ovalid_reg, ovalid_next;
    ibtc_pkg::kind_t     kind_reg, kind_next;
    logic [1:0]          smain_reg, smain_next;
    logic [2:0]          sdet_reg, sdet_next;
    logic [6:0]          otarget_reg, otarget_next;
    logic [1:0]          otkind_reg, otkind_next;
    logic [9:0]          rcount_reg, rcount_next;
    logic [5:0]          wlen_reg, wlen_next;
    logic [9:0]          bcount_reg, bcount_next;
    logic                last_reg, last_next;

    ibtc_pkg::alu_req_t   alu_req;
    logic [AW-1:0]        alu_y;
    ibtc_pkg::store_req_t st_req;
    logic [7:0]           st_q;

    logic                 in_acc;
    logic                 out_acc;
    ibtc_pkg::cmd_t       in_cmd;
    logic [CW-1:0]        idx_inc;
    logic [SW-1:0]        rd_addr_full;

    assign in_stall  = (state_reg != ibtc_pkg::S_READY);
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = ovalid_reg && !out_stall;
    assign in_cmd    = ibtc_pkg::cmd_t'(command);
    assign idx_inc   = CW'(idx_reg + 1'b1);

    ibtc_alu u_alu
    (
        .req (alu_req),
        .y   (alu_y)
    );

    ibtc_store u_store
    (
        .clk     (clk),
        .req     (st_req),
        .rd_data (st_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ibtc_pkg::S_READY:
            begin
                if (in_acc)
                begin
                    unique case (in_cmd)
                        ibtc_pkg::CMD_READ,
                        ibtc_pkg::CMD_WRITE_READ,
                        ibtc_pkg::CMD_WRITE:      state_next = ibtc_pkg::S_START_RD;
                        ibtc_pkg::CMD_FORCE_SEND: state_next = ibtc_pkg::S_FS_REMAIN;
                        ibtc_pkg::CMD_STATUS:     state_next = ibtc_pkg::S_STATUS_LOAD;
                        default:                  state_next = ibtc_pkg::S_READY;
                    endcase
                end
            end
            ibtc_pkg::S_START_RD:    state_next = ibtc_pkg::S_START_WR;
            ibtc_pkg::S_START_WR:    state_next = ibtc_pkg::S_START_LOAD;
            ibtc_pkg::S_START_LOAD:  state_next = ibtc_pkg::S_OUT_SINGLE;
            ibtc_pkg::S_STATUS_LOAD: state_next = ibtc_pkg::S_OUT_SINGLE;
            ibtc_pkg::S_FS_REMAIN:   state_next = ibtc_pkg::S_FS_LIMIT;
            ibtc_pkg::S_FS_LIMIT:    state_next = ibtc_pkg::S_FS_CHUNK;
            ibtc_pkg::S_FS_CHUNK:    state_next = ibtc_pkg::S_FS_HEADER;
            ibtc_pkg::S_FS_HEADER:   state_next = ibtc_pkg::S_OUT_HEADER;
            ibtc_pkg::S_OUT_SINGLE:
            begin
                if (out_acc)
                begin
                    state_next = ibtc_pkg::S_READY;
                end
            end
            ibtc_pkg::S_OUT_HEADER:
            begin
                if (out_acc)
                begin
                    state_next = (chunk_reg == '0) ? ibtc_pkg::S_READY
                                                   : ibtc_pkg::S_OUT_DATA;
                end
            end
            ibtc_pkg::S_OUT_DATA:
            begin
                if (out_acc && (idx_inc == chunk_reg))
                begin
                    state_next = ibtc_pkg::S_READY;
                end
            end
            default:                 state_next = ibtc_pkg::S_READY;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        wcnt_next     = wcnt_reg;
        main_next     = main_reg;
        detail_next   = detail_reg;
        done_len_next = done_len_reg;
        offset_next   = offset_reg;
        prd_len_next  = prd_len_reg;
        pwr_len_next  = pwr_len_reg;
        pkind_next    = pkind_reg;
        ptarget_next  = ptarget_reg;
        fill_next     = fill_reg;
        tmp_next      = tmp_reg;
        chunk_next    = chunk_reg;
        idx_next      = idx_reg;
        ovalid_next   = ovalid_reg;
        kind_next     = kind_reg;
        smain_next    = smain_reg;
        sdet_next     = sdet_reg;
        otarget_next  = otarget_reg;
        otkind_next   = otkind_reg;
        rcount_next   = rcount_reg;
        wlen_next     = wlen_reg;
        bcount_next   = bcount_reg;
        last_next     = last_reg;

        alu_req.op = ibtc_pkg::ALU_MIN;
        alu_req.a  = '0;
        alu_req.b  = '0;

        st_req.we    = 1'b0;
        st_req.waddr = fill_reg[SW-1:0];
        st_req.wdata = data_byte;
        st_req.re    = 1'b0;
        st_req.raddr = offset_reg[SW-1:0];

        rd_addr_full = offset_reg[SW-1:0] + SW'(idx_inc);

        unique case (state_reg)
            ibtc_pkg::S_READY:
            begin
                if (in_acc)
                begin
                    cmd_next  = in_cmd;
                    len_next  = length;
                    wcnt_next = write_count;
                    unique case (in_cmd)
                        ibtc_pkg::CMD_READ,
                        ibtc_pkg::CMD_WRITE_READ,
                        ibtc_pkg::CMD_WRITE:
                        begin
                            ptarget_next  = address_byte[7:1];
                            offset_next   = '0;
                            done_len_next = '0;
                            detail_next   = ibtc_pkg::DET_NACK;
                            fill_next     = '0;
                            main_next     = ibtc_pkg::MS_BUSY;
                            unique case (in_cmd)
                                ibtc_pkg::CMD_READ:       pkind_next = ibtc_pkg::XF_READ;
                                ibtc_pkg::CMD_WRITE_READ: pkind_next = ibtc_pkg::XF_WRITE_READ;
                                default:                  pkind_next = ibtc_pkg::XF_WRITE;
                            endcase
                        end
                        ibtc_pkg::CMD_CANCEL:
                        begin
                            main_next     = ibtc_pkg::MS_IDLE;
                            detail_next   = ibtc_pkg::DET_NACK;
                            done_len_next = '0;
                            offset_next   = '0;
                        end
                        ibtc_pkg::CMD_BUS_BYTE:
                        begin
                            if ((main_reg == ibtc_pkg::MS_BUSY) && (fill_reg < prd_len_reg))
                            begin
                                st_req.we = 1'b1;
                                fill_next = LW'(fill_reg + 1'b1);
                            end
                        end
                        ibtc_pkg::CMD_BUS_DONE:
                        begin
                            if (main_reg == ibtc_pkg::MS_BUSY)
                            begin
                                unique case (ibtc_pkg::bus_res_t'(bus_result))
                                    ibtc_pkg::RES_OK:
                                    begin
                                        done_len_next = (pkind_reg == ibtc_pkg::XF_WRITE)
                                                      ? LW'(pwr_len_reg) : prd_len_reg;
                                        detail_next   = ibtc_pkg::DET_SUCCESS;
                                        main_next     = ibtc_pkg::MS_COMPLETE;
                                    end
                                    ibtc_pkg::RES_TIMEOUT:
                                    begin
                                        detail_next = ibtc_pkg::DET_TIMEOUT;
                                        main_next   = ibtc_pkg::MS_ERROR;
                                    end
                                    ibtc_pkg::RES_RETRY:
                                    begin
                                        detail_next = ibtc_pkg::DET_ARB;
                                        main_next   = ibtc_pkg::MS_ERROR;
                                    end
                                    default:
                                    begin
                                        detail_next = ibtc_pkg::DET_NACK;
                                        main_next   = ibtc_pkg::MS_ERROR;
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ibtc_pkg::S_START_RD:
            begin
                alu_req.op   = ibtc_pkg::ALU_MIN;
                alu_req.a    = len_reg;
                alu_req.b    = AW'(ibtc_pkg::MAX_READ_BYTES);
                prd_len_next = (cmd_reg == ibtc_pkg::CMD_WRITE) ? '0 : alu_y[LW-1:0];
            end
            ibtc_pkg::S_START_WR:
            begin
                alu_req.op   = ibtc_pkg::ALU_MIN;
                alu_req.a    = AW'(wcnt_reg);
                alu_req.b    = (cmd_reg == ibtc_pkg::CMD_WRITE_READ)
                             ? AW'(ibtc_pkg::WR_RD_WRITE_MAX) : AW'(ibtc_pkg::WRITE_MAX);
                pwr_len_next = (cmd_reg == ibtc_pkg::CMD_READ) ? '0 : alu_y[WW-1:0];
            end
            ibtc_pkg::S_START_LOAD:
            begin
                ovalid_next  = 1'b1;
                kind_next    = ibtc_pkg::K_BUS_START;
                smain_next   = '0;
                sdet_next    = '0;
                otarget_next = ptarget_reg;
                otkind_next  = pkind_reg;
                rcount_next  = prd_len_reg;
                wlen_next    = pwr_len_reg;
                bcount_next  = '0;
                last_next    = 1'b1;
            end
            ibtc_pkg::S_STATUS_LOAD:
            begin
                ovalid_next  = 1'b1;
                kind_next    = ibtc_pkg::K_STATUS;
                smain_next   = main_reg;
                sdet_next    = detail_reg;
                otarget_next = '0;
                otkind_next  = '0;
                rcount_next  = '0;
                wlen_next    = '0;
                bcount_next  = done_len_reg;
                last_next    = 1'b1;
            end
            ibtc_pkg::S_FS_REMAIN:
            begin
                alu_req.op = ibtc_pkg::ALU_SUBSAT;
                alu_req.a  = AW'(done_len_reg);
                alu_req.b  = AW'(offset_reg);
                tmp_next   = alu_y[LW-1:0];
            end
            ibtc_pkg::S_FS_LIMIT:
            begin
                alu_req.op = ibtc_pkg::ALU_MIN;
                alu_req.a  = AW'(tmp_reg);
                alu_req.b  = len_reg;
                tmp_next   = alu_y[LW-1:0];
            end
            ibtc_pkg::S_FS_CHUNK:
            begin
                alu_req.op = ibtc_pkg::ALU_MIN;
                alu_req.a  = AW'(tmp_reg);
                alu_req.b  = AW'(ibtc_pkg::CHUNK_BYTES);
                chunk_next = alu_y[CW-1:0];
            end
            ibtc_pkg::S_FS_HEADER:
            begin
                ovalid_next  = 1'b1;
                kind_next    = ibtc_pkg::K_HEADER;
                smain_next   = (chunk_reg == '0) ? ibtc_pkg::MS_IDLE : ibtc_pkg::MS_COMPLETE;
                sdet_next    = '0;
                otarget_next = '0;
                otkind_next  = '0;
                rcount_next  = '0;
                wlen_next    = '0;
                bcount_next  = 10'(chunk_reg);
                last_next    = (chunk_reg == '0);
            end
            ibtc_pkg::S_OUT_SINGLE:
            begin
                if (out_acc)
                begin
                    ovalid_next = 1'b0;
                end
            end
            ibtc_pkg::S_OUT_HEADER:
            begin
                if (out_acc)
                begin
                    if (chunk_reg == '0)
                    begin
                        ovalid_next = 1'b0;
                    end
                    else
                    begin
                        // prefetch first byte
                        st_req.re    = 1'b1;
                        st_req.raddr = offset_reg[SW-1:0];
                        idx_next     = '0;
                        kind_next    = ibtc_pkg::K_DATA;
                        smain_next   = '0;
                        bcount_next  = '0;
                        last_next    = (chunk_reg == CW'(1));
                    end
                end
            end
            ibtc_pkg::S_OUT_DATA:
            begin
                if (out_acc)
                begin
                    if (idx_inc == chunk_reg)
                    begin
                        ovalid_next = 1'b0;
                        offset_next = offset_reg + LW'(chunk_reg);
                    end
                    else
                    begin
                        st_req.re    = 1'b1;
                        st_req.raddr = rd_addr_full;
                        idx_next     = idx_inc;
                        last_next    = (CW'(idx_inc + 1'b1) == chunk_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibtc_pkg::S_READY;
            cmd_reg       <= ibtc_pkg::CMD_READ;
            len_reg       <= '0;
            wcnt_reg      <= '0;
            main_reg      <= ibtc_pkg::MS_IDLE;
            detail_reg    <= ibtc_pkg::DET_NACK;
            done_len_reg  <= '0;
            offset_reg    <= '0;
            prd_len_reg   <= '0;
            pwr_len_reg   <= '0;
            pkind_reg     <= ibtc_pkg::XF_READ;
            ptarget_reg   <= '0;
            fill_reg      <= '0;
            tmp_reg       <= '0;
            chunk_reg     <= '0;
            idx_reg       <= '0;
            ovalid_reg    <= 1'b0;
            kind_reg      <= ibtc_pkg::K_BUS_START;
            smain_reg     <= '0;
            sdet_reg      <= '0;
            otarget_reg   <= '0;
            otkind_reg    <= '0;
            rcount_reg    <= '0;
            wlen_reg      <= '0;
            bcount_reg    <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            len_reg       <= len_next;
            wcnt_reg      <= wcnt_next;
            main_reg      <= main_next;
            detail_reg    <= detail_next;
            done_len_reg  <= done_len_next;
            offset_reg    <= offset_next;
            prd_len_reg   <= prd_len_next;
            pwr_len_reg   <= pwr_len_next;
            pkind_reg     <= pkind_next;
            ptarget_reg   <= ptarget_next;
            fill_reg      <= fill_next;
            tmp_reg       <= tmp_next;
            chunk_reg     <= chunk_next;
            idx_reg       <= idx_next;
            ovalid_reg    <= ovalid_next;
            kind_reg      <= kind_next;
            smain_reg     <= smain_next;
            sdet_reg      <= sdet_next;
            otarget_reg   <= otarget_next;
            otkind_reg    <= otkind_next;
            rcount_reg    <= rcount_next;
            wlen_reg      <= wlen_next;
            bcount_reg    <= bcount_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid     = ovalid_reg;
    assign kind          = kind_reg;
    assign status_main   = smain_reg;
    assign status_detail = sdet_reg;
    assign target        = otarget_reg;
    assign transfer_kind = otkind_reg;
    assign read_count    = rcount_reg;
    assign write_bytes   = wlen_reg;
    assign byte_count    = bcount_reg;
    assign read_data     = (kind_reg == ibtc_pkg::K_DATA) ? st_q : 8'd0;
    assign last          = last_reg;

endmodule

// ===== tb/tb_i2c_bridge_transfer_control.sv =====
// ----------------------------------------------------------------------------
// tb_i2c_bridge_transfer_control
// Self-checking bench for the I2C bridge transfer control engine. Directed
// requests hit the clamps, every bus result code, cancel, idle bus items and
// force send while busy or empty. Random transfer sequences follow: start,
// bus bytes, done or cancel, status and chunked force sends. Both sides stall
// in random bursts. A tracker class predicts every result and checks them in
// order.
// ----------------------------------------------------------------------------
module tb_i2c_bridge_transfer_control;
    import ibtc_pkg::*;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] addr;
        logic [15:0] len;
        logic [7:0] wcnt;
        logic [7:0] dbyte;
        bus_res_t   bres;
    } bridge_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] smain;
        logic [2:0] det;
        logic [6:0] tgt;
        logic [1:0] xk;
        logic [9:0] rcnt;
        logic [5:0] wlen;
        logic [9:0] bcnt;
        logic [7:0] data;
        logic       last;
    } bridge_reply_t;

    class bridge_status_tracker;
        main_t      main_state = MS_IDLE;
        detail_t    detail = DET_NACK;
        xfer_t      xfer = XF_READ;
        logic [9:0] done_len = '0;
        logic [9:0] rd_off = '0;
        logic [9:0] rd_len = '0;
        logic [9:0] fill_idx = '0;
        logic [5:0] wr_len = '0;
        logic [6:0] tgt = '0;
        logic [7:0] store [MAX_READ_BYTES];
        bit         written [MAX_READ_BYTES];
        bridge_reply_t pending_replies [$];
        int mismatches = 0;
        int replies_checked = 0;
        int requests_taken = 0;
        int ignored_bus_items = 0;

        function int unsigned chunk_for(int unsigned len);
            int unsigned remaining;
            int unsigned chunk;
            remaining = (done_len > rd_off) ? done_len - rd_off : 0;
            chunk = (remaining < len) ? remaining : len;
            return (chunk > CHUNK_BYTES) ? CHUNK_BYTES : chunk;
        endfunction

        // limit a force-send length so it never touches never-written store entries
        function int unsigned safe_fs_len(int unsigned len);
            int unsigned chunk;
            chunk = chunk_for(len);
            for (int unsigned i = 0; i < chunk; i++)
                if (!written[rd_off + i])
                    return i;
            return len;
        endfunction

        function void take_request(bridge_req_t q);
            bridge_reply_t r;
            int unsigned chunk;
            r = '0;
            if ((q.cmd == CMD_BUS_BYTE || q.cmd == CMD_BUS_DONE) && main_state != MS_BUSY)
            begin
                ignored_bus_items++;
                return;
            end
            requests_taken++;
            case (q.cmd)
                CMD_READ, CMD_WRITE_READ, CMD_WRITE:
                begin
                    tgt = q.addr[7:1];
                    if (q.cmd == CMD_WRITE)
                    begin
                        rd_len = '0;
                        wr_len = (q.wcnt > WRITE_MAX) ? 6'(WRITE_MAX) : q.wcnt[5:0];
                        xfer = XF_WRITE;
                    end
                    else
                    begin
                        rd_len = (q.len > MAX_READ_BYTES) ? 10'(MAX_READ_BYTES) : q.len[9:0];
                        if (q.cmd == CMD_READ)
                        begin
                            wr_len = '0;
                            xfer = XF_READ;
                        end
                        else
                        begin
                            wr_len = (q.wcnt > WR_RD_WRITE_MAX) ? 6'(WR_RD_WRITE_MAX)
                                                                 : q.wcnt[5:0];
                            xfer = XF_WRITE_READ;
                        end
                    end
                    rd_off = '0;
                    done_len = '0;
                    detail = DET_NACK;
                    fill_idx = '0;
                    main_state = MS_BUSY;
                    r.kind = K_BUS_START;
                    r.tgt = tgt;
                    r.xk = xfer;
                    r.rcnt = rd_len;
                    r.wlen = wr_len;
                    r.last = 1'b1;
                    pending_replies.push_back(r);
                end
                CMD_FORCE_SEND:
                begin
                    chunk = chunk_for(q.len);
                    r.kind = K_HEADER;
                    r.smain = (chunk == 0) ? MS_IDLE : MS_COMPLETE;
                    r.bcnt = 10'(chunk);
                    r.last = (chunk == 0);
                    pending_replies.push_back(r);
                    for (int unsigned i = 0; i < chunk; i++)
                    begin
                        r = '0;
                        r.kind = K_DATA;
                        r.data = store[rd_off + i];
                        r.last = (i + 1 == chunk);
                        pending_replies.push_back(r);
                    end
                    rd_off = rd_off + 10'(chunk);
                end
                CMD_STATUS:
                begin
                    r.kind = K_STATUS;
                    r.smain = main_state;
                    r.det = detail;
                    r.bcnt = done_len;
                    r.last = 1'b1;
                    pending_replies.push_back(r);
                end
                CMD_CANCEL:
                begin
                    main_state = MS_IDLE;
                    detail = DET_NACK;
                    done_len = '0;
                    rd_off = '0;
                end
                CMD_BUS_BYTE:
                begin
                    if (fill_idx < rd_len)
                    begin
                        store[fill_idx] = q.dbyte;
                        written[fill_idx] = 1'b1;
                        fill_idx++;
                    end
                end
                default:
                begin
                    case (q.bres)
                        RES_OK:
                        begin
                            done_len = (xfer == XF_WRITE) ? 10'(wr_len) : rd_len;
                            detail = DET_SUCCESS;
                        end
                        RES_TIMEOUT: detail = DET_TIMEOUT;
                        RES_RETRY:   detail = DET_ARB;
                        default:     detail = DET_NACK;
                    endcase
                    main_state = (q.bres == RES_OK) ? MS_COMPLETE : MS_ERROR;
                end
            endcase
        endfunction

        function void cmp(string name, int unsigned e, int unsigned a);
            if (e != a)
            begin
                mismatches++;
                $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name, e, a);
            end
        endfunction

        function void check_reply(bridge_reply_t a);
            bridge_reply_t e;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $display("[%0t] result with none expected: expected nothing, actual kind %0d",
                         $time, a.kind);
                return;
            end
            e = pending_replies.pop_front();
            replies_checked++;
            cmp("kind", e.kind, a.kind);
            cmp("status_main", e.smain, a.smain);
            cmp("status_detail", e.det, a.det);
            cmp("target", e.tgt, a.tgt);
            cmp("transfer_kind", e.xk, a.xk);
            cmp("read_count", e.rcnt, a.rcnt);
            cmp("write_bytes", e.wlen, a.wlen);
            cmp("byte_count", e.bcnt, a.bcnt);
            cmp("read_data", e.data, a.data);
            cmp("last", e.last, a.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [7:0]  address_byte = '0;
    logic [15:0] length = '0;
    logic [7:0]  write_count = '0;
    logic [7:0]  data_byte = '0;
    logic [1:0]  bus_result = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  status_main;
    logic [2:0]  status_detail;
    logic [6:0]  target;
    logic [1:0]  transfer_kind;
    logic [9:0]  read_count;
    logic [5:0]  write_bytes;
    logic [9:0]  byte_count;
    logic [7:0]  read_data;
    logic        last;

    bridge_status_tracker tracker = new();
    bit quiet = 1'b0;
    int stall_left = 0;

    i2c_bridge_transfer_control DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .command(command),
        .address_byte(address_byte),
        .length(length),
        .write_count(write_count),
        .data_byte(data_byte),
        .bus_result(bus_result),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .status_main(status_main),
        .status_detail(status_detail),
        .target(target),
        .transfer_kind(transfer_kind),
        .read_count(read_count),
        .write_bytes(write_bytes),
        .byte_count(byte_count),
        .read_data(read_data),
        .last(last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reply({kind, status_main, status_detail, target, transfer_kind,
                                 read_count, write_bytes, byte_count, read_data, last});
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 6);
        end
    end

    task automatic send_request(cmd_t c, logic [7:0] a, logic [15:0] l, logic [7:0] w,
                                logic [7:0] d, bus_res_t b);
        bridge_req_t q;
        q = '{cmd: c, addr: a, len: l, wcnt: w, dbyte: d, bres: b};
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= c;
        address_byte <= a;
        length <= l;
        write_count <= w;
        data_byte <= d;
        bus_result <= b;
        do @(posedge clk); while (in_stall);
        tracker.take_request(q);
    endtask

    task automatic force_send(logic [15:0] l);
        send_request(CMD_FORCE_SEND, 8'($urandom), 16'(tracker.safe_fs_len(l)),
                     8'($urandom), 8'($urandom), bus_res_t'($urandom));
    endtask

    task automatic plain(cmd_t c, bus_res_t b);
        send_request(c, 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), b);
    endtask

    function automatic logic [15:0] pick_read_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(0, 24));
        if (r < 90)
            return 16'($urandom_range(25, 70));
        if (r < 95)
            return 16'($urandom);
        return (r < 97) ? 16'(MAX_READ_BYTES) : 16'hFFFF;
    endfunction

    function automatic logic [15:0] pick_fs_len();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 16'hFFFF;
        if (r < 8)
            return 16'($urandom_range(0, 70));
        return 16'($urandom);
    endfunction

    task automatic finish_transfer();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            plain(CMD_BUS_DONE, RES_OK);
        else if (r < 9)
            plain(CMD_BUS_DONE, bus_res_t'($urandom_range(1, 3)));
        else
            plain(CMD_CANCEL, bus_res_t'($urandom));
        if ($urandom_range(0, 2) != 0)
            plain(CMD_STATUS, bus_res_t'($urandom));
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 11) == 0)
                plain(CMD_CANCEL, bus_res_t'($urandom));
            force_send(pick_fs_len());
        end
    endtask

    task automatic read_transfer();
        int unsigned n;
        int unsigned r;
        send_request(($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE_READ, 8'($urandom),
                     pick_read_len(), 8'($urandom), 8'($urandom), bus_res_t'($urandom));
        n = (tracker.rd_len > 70) ? $urandom_range(0, 30) : tracker.rd_len;
        r = $urandom_range(0, 9);
        if (r == 0 && n > 0)
            n = $urandom_range(0, n - 1);
        else if (r == 1)
            n += $urandom_range(1, 3);
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 29) == 0)
                force_send(pick_fs_len());
            plain(CMD_BUS_BYTE, bus_res_t'($urandom));
        end
        finish_transfer();
    endtask

    task automatic write_transfer();
        plain(CMD_WRITE, bus_res_t'($urandom));
        if ($urandom_range(0, 3) == 0)
            plain(CMD_BUS_BYTE, bus_res_t'($urandom));
        finish_transfer();
    endtask

    task automatic noise_burst();
        cmd_t c;
        repeat ($urandom_range(1, 4))
        begin
            c = cmd_t'($urandom_range(0, 7));
            if (c == CMD_FORCE_SEND)
                force_send(16'($urandom));
            else
                plain(c, bus_res_t'($urandom));
        end
    endtask

    initial
    begin
        int unsigned r;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_request(CMD_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_FORCE_SEND, 8'h00, 16'hFFFF, 8'h00, 8'h00, RES_OK);
        send_request(CMD_BUS_BYTE, 8'h00, 16'h0000, 8'h00, 8'hFF, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_READ, 8'hFF, 16'hFFFF, 8'h00, 8'h00, RES_OK);
        send_request(CMD_FORCE_SEND, 8'h00, 16'd10, 8'h00, 8'h00, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_TIMEOUT);
        send_request(CMD_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_WRITE_READ, 8'h00, 16'd3, 8'hFF, 8'h00, RES_OK);
        send_request(CMD_BUS_BYTE, 8'h00, 16'h0000, 8'h00, 8'hFF, RES_OK);
        send_request(CMD_BUS_BYTE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_BUS_BYTE, 8'h00, 16'h0000, 8'h00, 8'hA5, RES_OK);
        send_request(CMD_BUS_BYTE, 8'h00, 16'h0000, 8'h00, 8'h5A, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        force_send(16'd2);
        force_send(16'hFFFF);
        force_send(16'hFFFF);
        send_request(CMD_WRITE, 8'h80, 16'h0000, 8'hFF, 8'h00, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_RETRY);
        send_request(CMD_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_WRITE, 8'h55, 16'h0000, 8'd3, 8'h00, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        force_send(16'd10);
        send_request(CMD_READ, 8'hAA, 16'd0, 8'h00, 8'h00, RES_OK);
        send_request(CMD_BUS_DONE, 8'h00, 16'h0000, 8'h00, 8'h00, RES_NACK);
        send_request(CMD_CANCEL, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);
        send_request(CMD_STATUS, 8'h00, 16'h0000, 8'h00, 8'h00, RES_OK);

        while (tracker.requests_taken + tracker.ignored_bus_items < 245)
        begin
            quiet <= (tracker.requests_taken + tracker.ignored_bus_items > 205);
            r = $urandom_range(0, 99);
            if (r < 50)
                read_transfer();
            else if (r < 70)
                write_transfer();
            else if (r < 85)
                noise_burst();
            else
            begin
                plain(($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_READ, bus_res_t'($urandom));
                read_transfer();
            end
        end
        in_valid <= 1'b0;

        while (tracker.pending_replies.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Run: %0d requests, %0d idle bus items ignored, %0d results checked,",
                 tracker.requests_taken, tracker.ignored_bus_items, tracker.replies_checked);
        $display("     over clamped starts, bus errors, cancels, status and chunked reads.");
        if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", tracker.pending_replies.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
